[hw/rtl/window_aggregate_unit_macros.svh]
// Assertion macros shared by the window aggregate unit checkers.
// Depends on clk_i and rst_ni being visible at the point of use.
`ifndef WINDOW_AGGREGATE_UNIT_MACROS_SVH
`define WINDOW_AGGREGATE_UNIT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define WAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same, built on the macro above with a fixed message
`define WAU_ASSERT_PORT(label, prop) \
  `WAU_ASSERT(label, prop, "window_aggregate_unit port check failed")

`endif

[hw/rtl/wau_pkg.sv]
// Package for the window aggregate unit: constants, mode codes, FSM state and
// controller/datapath command and status types. No dependencies.
package wau_pkg;

  localparam int unsigned DEF_MAX_WINDOW_ITEMS = 65536;
  localparam int unsigned DEF_VALUE_WIDTH      = 48;
  localparam int unsigned SUM_W                = 64;
  localparam int unsigned TIME_W               = 64;
  localparam int unsigned MODE_W               = 3;
  localparam int unsigned OUT_TDATA_W          = SUM_W + TIME_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_COUNT = 3'd0,
    MODE_SUM   = 3'd1,
    MODE_MIN   = 3'd2,
    MODE_MAX   = 3'd3,
    MODE_AVG   = 3'd4
  } agg_mode_e;

  typedef enum logic [1:0] {
    ST_ACCUM  = 2'd0,
    ST_FINISH = 2'd1,
    ST_DIVIDE = 2'd2
  } wau_state_e;

  typedef struct packed {
    logic acc_en;
    logic clear;
    logic div_start;
    logic div_step;
    logic out_load;
    logic out_from_div;
  } wau_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } wau_sts_t;

endpackage

[hw/rtl/window_aggregate_unit.sv]
// Window aggregate unit top level: count, sum, min, max or average per window.
// Items: one per cycle within a window; a closing item blocks input until its result is loaded.
// The result register loads once the output is free, after the 64-step bit-serial divider
// when average mode has valid items. Reset clears mode to count and empties the window.
// Depends on wau_pkg, wau_ctrl and wau_dp.
module window_aggregate_unit #(
  parameter int unsigned MAX_WINDOW_ITEMS = wau_pkg::DEF_MAX_WINDOW_ITEMS,
  parameter int unsigned VALUE_WIDTH      = wau_pkg::DEF_VALUE_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [wau_pkg::MODE_W-1:0]           cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_value, window_end_time, zero pad
  input  logic [((VALUE_WIDTH + wau_pkg::TIME_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // has_element, value_ok
  input  logic [1:0]                           s_axis_tuser,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // result_value, result_time
  output logic [wau_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // empty_window
  output logic [0:0]                           m_axis_tuser
);
  import wau_pkg::*;

  wau_cmd_t            cmd;
  wau_sts_t            sts;
  logic [SUM_W-1:0]    result_value;
  logic [TIME_W-1:0]   result_time;
  logic                empty_window;

  wau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wau_dp #(
    .MAX_WINDOW_ITEMS (MAX_WINDOW_ITEMS),
    .VALUE_WIDTH      (VALUE_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .has_element_i     (s_axis_tuser[0]),
    .value_ok_i        (s_axis_tuser[1]),
    .sample_value_i    (s_axis_tdata[VALUE_WIDTH-1:0]),
    .window_end_time_i (s_axis_tdata[VALUE_WIDTH +: TIME_W]),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .result_value_o    (result_value),
    .result_time_o     (result_time),
    .empty_window_o    (empty_window)
  );

  assign m_axis_tdata = {result_time, result_value};
  assign m_axis_tuser = empty_window;

endmodule

[hw/rtl/wau_ctrl.sv]
// Controller of the window aggregate unit: window FSM and output valid flag.
// Depends on wau_pkg; drives the datapath wau_dp through wau_cmd_t.
module wau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tlast_i,
  output logic              s_tready_o,
  input  logic              m_tready_i,
  output logic              m_tvalid_o,
  input  wau_pkg::wau_sts_t sts_i,
  output wau_pkg::wau_cmd_t cmd_o
);
  import wau_pkg::*;

  wau_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;
  logic       out_free;

  assign in_fire  = s_tvalid_i && (state_q == ST_ACCUM);
  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACCUM: begin
        if (in_fire && s_tlast_i) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = sts_i.need_div ? ST_DIVIDE : ST_ACCUM;
      end
      ST_DIVIDE: begin
        if (sts_i.div_done) state_d = ST_ACCUM;
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_ACCUM: begin
        s_tready_o   = 1'b1;
        cmd_o.acc_en = in_fire;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.clear     = 1'b1;
          cmd_o.div_start = sts_i.need_div;
          cmd_o.out_load  = !sts_i.need_div;
        end
      end
      ST_DIVIDE: begin
        if (sts_i.div_done) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_from_div = 1'b1;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign m_tvalid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hw/rtl/wau_dp.sv]
// Datapath of the window aggregate unit: accumulators, mode register,
// bit-serial divider and output register. Depends on wau_pkg; driven by wau_ctrl.
module wau_dp #(
  parameter int unsigned MAX_WINDOW_ITEMS = wau_pkg::DEF_MAX_WINDOW_ITEMS,
  parameter int unsigned VALUE_WIDTH      = wau_pkg::DEF_VALUE_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wau_pkg::MODE_W-1:0]       cfg_wdata_i,
  input  logic                             has_element_i,
  input  logic                             value_ok_i,
  input  logic signed [VALUE_WIDTH-1:0]    sample_value_i,
  input  logic [wau_pkg::TIME_W-1:0]       window_end_time_i,
  input  wau_pkg::wau_cmd_t                cmd_i,
  output wau_pkg::wau_sts_t                sts_o,
  output logic [wau_pkg::SUM_W-1:0]        result_value_o,
  output logic [wau_pkg::TIME_W-1:0]       result_time_o,
  output logic                             empty_window_o
);
  import wau_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW_ITEMS + 1);
  localparam int unsigned DCNT_W = $clog2(SUM_W + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW_ITEMS);
  localparam logic signed [VALUE_WIDTH-1:0] VAL_TOP = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_BOT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [SUM_W-1:0] SUM_TOP = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_BOT = {1'b1, {(SUM_W-1){1'b0}}};

  logic [MODE_W-1:0]             agg_mode_q;
  agg_mode_e                     mode;
  logic [CNT_W-1:0]              elem_cnt_q, elem_cnt_d;
  logic [CNT_W-1:0]              valid_cnt_q, valid_cnt_d;
  logic [SUM_W-1:0]              sum_q, sum_d;
  logic signed [VALUE_WIDTH-1:0] min_q, min_d;
  logic signed [VALUE_WIDTH-1:0] max_q, max_d;
  logic [TIME_W-1:0]             time_q;
  logic [SUM_W-1:0]              sample_ext;
  logic [SUM_W:0]                sum_wide;
  logic [SUM_W-1:0]              sum_sat;

  logic [CNT_W-1:0]              divisor_q;
  logic [CNT_W-1:0]              rem_q, rem_d;
  logic [SUM_W-1:0]              quo_q, quo_d;
  logic [DCNT_W-1:0]             dcnt_q;
  logic                          neg_q;
  logic [CNT_W:0]                rem_shift;
  logic [CNT_W:0]                rem_trial;
  logic [SUM_W-1:0]              div_value;

  logic [SUM_W-1:0]              sel_value;
  logic                          sel_empty;
  logic [SUM_W-1:0]              out_value_q;
  logic [TIME_W-1:0]             out_time_q;
  logic                          out_empty_q;

  assign mode = agg_mode_e'(agg_mode_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agg_mode_q <= MODE_COUNT;
    end else if (cfg_we_i) begin
      agg_mode_q <= cfg_wdata_i;
    end
  end

  assign sample_ext = SUM_W'(sample_value_i);
  assign sum_wide   = {sum_q[SUM_W-1], sum_q} + {sample_ext[SUM_W-1], sample_ext};

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_BOT : SUM_TOP;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    elem_cnt_d  = elem_cnt_q;
    valid_cnt_d = valid_cnt_q;
    sum_d       = sum_q;
    min_d       = min_q;
    max_d       = max_q;
    priority if (cmd_i.clear) begin
      elem_cnt_d  = '0;
      valid_cnt_d = '0;
      sum_d       = '0;
      min_d       = VAL_TOP;
      max_d       = VAL_BOT;
    end else if (cmd_i.acc_en && has_element_i) begin
      if (elem_cnt_q < CNT_MAX) elem_cnt_d = elem_cnt_q + 1'b1;
      if (value_ok_i) begin
        if (valid_cnt_q < CNT_MAX) valid_cnt_d = valid_cnt_q + 1'b1;
        sum_d = sum_sat;
        if (sample_value_i < min_q) min_d = sample_value_i;
        if (sample_value_i > max_q) max_d = sample_value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_cnt_q  <= '0;
      valid_cnt_q <= '0;
      sum_q       <= '0;
      min_q       <= VAL_TOP;
      max_q       <= VAL_BOT;
    end else begin
      elem_cnt_q  <= elem_cnt_d;
      valid_cnt_q <= valid_cnt_d;
      sum_q       <= sum_d;
      min_q       <= min_d;
      max_q       <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) time_q <= window_end_time_i;
  end

  always_comb begin
    sel_value = '0;
    sel_empty = 1'b1;
    if (elem_cnt_q != '0) begin
      sel_empty = 1'b0;
      unique case (mode)
        MODE_COUNT: sel_value = SUM_W'(elem_cnt_q);
        MODE_SUM:   sel_value = sum_q;
        MODE_MIN:   sel_value = SUM_W'(min_q);
        MODE_MAX:   sel_value = SUM_W'(max_q);
        MODE_AVG:   sel_value = '0;
        default:    sel_empty = 1'b1;
      endcase
    end
  end

  assign sts_o.need_div = (elem_cnt_q != '0) && (mode == MODE_AVG) && (valid_cnt_q != '0);
  assign sts_o.div_done = (dcnt_q == DCNT_W'(SUM_W));

  // restoring division, one quotient bit per step
  assign rem_shift = {rem_q, quo_q[SUM_W-1]};
  assign rem_trial = rem_shift - {1'b0, divisor_q};

  always_comb begin
    if (!rem_trial[CNT_W]) begin
      rem_d = rem_trial[CNT_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], 1'b1};
    end else begin
      rem_d = rem_shift[CNT_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q     <= sum_q[SUM_W-1];
      quo_q     <= sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
      divisor_q <= valid_cnt_q;
      rem_q     <= '0;
      dcnt_q    <= '0;
    end else if (cmd_i.div_step) begin
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  assign div_value = neg_q ? (SUM_W'(0) - quo_q) : quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q <= cmd_i.out_from_div ? div_value : sel_value;
      out_empty_q <= cmd_i.out_from_div ? 1'b0 : sel_empty;
      out_time_q  <= time_q;
    end
  end

  assign result_value_o = out_value_q;
  assign result_time_o  = out_time_q;
  assign empty_window_o = out_empty_q;

endmodule

[hw/rtl/wau_checker.sv]
// Port-level checker for the window aggregate unit, bound to the top level.
// Depends on window_aggregate_unit_macros.svh and wau_pkg.
`include "window_aggregate_unit_macros.svh"

module wau_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              s_axis_tlast,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [wau_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic [0:0]                        m_axis_tuser
);
  import wau_pkg::*;

  `WAU_ASSERT_PORT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `WAU_ASSERT_PORT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `WAU_ASSERT_PORT(a_empty_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[SUM_W-1:0] == '0)
  `WAU_ASSERT(a_close_stall, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready,
    "input accepted right after a closing transaction")

endmodule

bind window_aggregate_unit wau_checker u_wau_checker (.*);

[dv/tb_top.sv]
// Testbench for window_aggregate_unit: directed table, long windows and random windows,
// checked against an in-bench predictor of count, sum, min, max and average per window.
// Depends on wau_pkg and window_aggregate_unit.
`timescale 1ns / 1ps

module tb_top;
  import wau_pkg::*;

  localparam int unsigned IN_W         = ((DEF_VALUE_WIDTH + TIME_W + 7) / 8) * 8;
  localparam int unsigned MAX_ITEMS    = DEF_MAX_WINDOW_ITEMS;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam int unsigned LONG_ITEMS   = 24;
  localparam int          N_PLAN       = 21;
  localparam int          N_PHASES     = 8;
  localparam int          PHASE_ITEMS  = 72;

  localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;

  localparam logic [47:0] VAL_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] VAL_MIN = 48'h8000_0000_0000;
  localparam logic signed [63:0] SUM_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_BOT = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] MIN_IDLE = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] MAX_IDLE = 64'shFFFF_8000_0000_0000;

  typedef struct packed {
    logic        has;
    logic        ok;
    logic [47:0] value;
    logic        last;
    logic [63:0] tstamp;
  } win_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [63:0] tstamp;
    logic        empty;
  } win_result_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              has;
    logic              ok;
    logic [47:0]       value;
    logic              last;
    logic [63:0]       tstamp;
    logic              known;
    logic [63:0]       exp_value;
    logic              exp_empty;
  } plan_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [MODE_W-1:0]      cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  window_aggregate_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [MODE_W-1:0]  mode_q = MODE_COUNT;
  int unsigned        elem_cnt;
  int unsigned        valid_cnt;
  logic signed [63:0] acc_sum;
  logic signed [63:0] acc_min;
  logic signed [63:0] acc_max;

  win_result_t window_q[$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned windows_closed = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  plan_row_t plan [N_PLAN] = '{
    '{MODE_COUNT, 1'b0, 1'b0, 48'h0, 1'b1, 64'h0, 1'b1, 64'h0, 1'b1},
    '{MODE_COUNT, 1'b1, 1'b0, 48'h0, 1'b0, 64'h1, 1'b0, 64'h0, 1'b0},
    '{MODE_COUNT, 1'b1, 1'b1, VAL_MAX, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'd2, 1'b0},
    '{MODE_SUM, 1'b1, 1'b1, VAL_MAX, 1'b0, 64'h2, 1'b0, 64'h0, 1'b0},
    '{MODE_SUM, 1'b1, 1'b1, VAL_MIN, 1'b0, 64'h3, 1'b0, 64'h0, 1'b0},
    '{MODE_SUM, 1'b0, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b0, 64'h4, 1'b0, 64'h0, 1'b0},
    '{MODE_SUM, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b1, 64'h8000_0000_0000_0000, 1'b1,
      64'hFFFF_FFFF_FFFF_FFFE, 1'b0},
    '{MODE_SUM, 1'b1, 1'b0, VAL_MAX, 1'b1, 64'h5, 1'b1, 64'h0, 1'b0},
    '{MODE_MIN, 1'b1, 1'b1, 48'h0000_0005_0000, 1'b0, 64'h6, 1'b0, 64'h0, 1'b0},
    '{MODE_MIN, 1'b1, 1'b1, 48'hFFFF_FFFD_0000, 1'b1, 64'h7, 1'b1,
      64'hFFFF_FFFF_FFFD_0000, 1'b0},
    '{MODE_MIN, 1'b1, 1'b0, VAL_MIN, 1'b1, 64'h8, 1'b1, MIN_IDLE, 1'b0},
    '{MODE_MAX, 1'b1, 1'b1, VAL_MIN, 1'b1, 64'h9, 1'b1, MAX_IDLE, 1'b0},
    '{MODE_MAX, 1'b1, 1'b0, VAL_MAX, 1'b1, 64'hA, 1'b1, MAX_IDLE, 1'b0},
    '{MODE_AVG, 1'b1, 1'b1, 48'd7, 1'b0, 64'hB, 1'b0, 64'h0, 1'b0},
    '{MODE_AVG, 1'b1, 1'b0, 48'd100, 1'b0, 64'hC, 1'b0, 64'h0, 1'b0},
    '{MODE_AVG, 1'b1, 1'b1, 48'hFFFF_FFFF_FFF4, 1'b0, 64'hD, 1'b0, 64'h0, 1'b0},
    '{MODE_AVG, 1'b1, 1'b1, 48'h0, 1'b1, 64'hE, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    '{MODE_AVG, 1'b1, 1'b0, 48'd9, 1'b1, 64'hF, 1'b1, 64'h0, 1'b0},
    '{MODE_AVG, 1'b0, 1'b1, 48'd9, 1'b1, 64'h10, 1'b1, 64'h0, 1'b1},
    '{MODE_RSVD_HI, 1'b1, 1'b1, 48'd1, 1'b1, 64'h11, 1'b1, 64'h0, 1'b1},
    '{MODE_RSVD_LO, 1'b1, 1'b1, 48'd1, 1'b1, 64'h12, 1'b1, 64'h0, 1'b1}
  };

  function automatic void clear_window();
    elem_cnt  = 0;
    valid_cnt = 0;
    acc_sum   = '0;
    acc_min   = MIN_IDLE;
    acc_max   = MAX_IDLE;
  endfunction

  function automatic bit fold_item(input win_item_t it, output win_result_t r);
    logic signed [63:0] v;
    logic signed [64:0] wide;
    logic [63:0]        mag;
    logic [63:0]        quo;
    v = {{16{it.value[47]}}, it.value};
    r = '0;
    if (it.has) begin
      if (elem_cnt < MAX_ITEMS) elem_cnt++;
      if (it.ok) begin
        if (valid_cnt < MAX_ITEMS) valid_cnt++;
        wide = {acc_sum[63], acc_sum} + {v[63], v};
        if (wide[64] != wide[63]) acc_sum = wide[64] ? SUM_BOT : SUM_TOP;
        else acc_sum = wide[63:0];
        if (v < acc_min) acc_min = v;
        if (v > acc_max) acc_max = v;
      end
    end
    if (!it.last) return 1'b0;
    r.tstamp = it.tstamp;
    r.empty  = (elem_cnt == 0);
    if (!r.empty) begin
      case (mode_q)
        MODE_COUNT: r.value = 64'(elem_cnt);
        MODE_SUM:   r.value = acc_sum;
        MODE_MIN:   r.value = acc_min;
        MODE_MAX:   r.value = acc_max;
        MODE_AVG: begin
          if (valid_cnt != 0) begin
            mag = acc_sum[63] ? -acc_sum : acc_sum;
            quo = mag / 64'(valid_cnt);
            r.value = acc_sum[63] ? -quo : quo;
          end
        end
        default: r.empty = 1'b1;
      endcase
    end
    clear_window();
    return 1'b1;
  endfunction

  task automatic offer(input win_item_t it, input bit known, input logic [63:0] kval,
                       input bit kempty);
    win_result_t r;
    int          gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({it.tstamp, it.value});
    s_axis_tuser  <= {it.ok, it.has};
    s_axis_tlast  <= it.last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (it.has || it.last) items_sent++;
    if (fold_item(it, r)) begin
      if (known) begin
        r.value = kval;
        r.empty = kempty;
      end
      window_q.push_back(r);
      windows_closed++;
    end
  endtask

  task automatic set_mode(input logic [MODE_W-1:0] m);
    s_axis_tvalid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = m;
  endtask

  function automatic logic [47:0] rand_value();
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return 48'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      3: return 48'($urandom_range(0, 15));
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  task automatic send_window(input int len);
    win_item_t it;
    int        k;
    if (len == 0) begin
      it.has    = 1'b0;
      it.ok     = 1'($urandom_range(0, 1));
      it.value  = rand_value();
      it.last   = 1'b1;
      it.tstamp = {$urandom, $urandom};
      offer(it, 1'b0, '0, 1'b0);
      return;
    end
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 15) == 0) begin
        it.has    = 1'b0;
        it.ok     = 1'($urandom_range(0, 1));
        it.value  = rand_value();
        it.last   = 1'b0;
        it.tstamp = {$urandom, $urandom};
        offer(it, 1'b0, '0, 1'b0);
      end
      it.last   = (k == len - 1);
      it.has    = it.last ? ($urandom_range(0, 9) != 0) : 1'b1;
      it.ok     = ($urandom_range(0, 4) != 0);
      it.value  = rand_value();
      it.tstamp = {$urandom, $urandom};
      offer(it, 1'b0, '0, 1'b0);
    end
  endtask

  task automatic long_window(input logic [MODE_W-1:0] m, input logic [47:0] v,
                             input bit mixed);
    win_item_t it;
    int        k;
    set_mode(m);
    for (k = 0; k < LONG_ITEMS; k++) begin
      it.has    = 1'b1;
      it.ok     = mixed ? ($urandom_range(0, 3) != 0) : 1'b1;
      it.value  = mixed ? rand_value() : v;
      it.last   = (k == LONG_ITEMS - 1);
      it.tstamp = {$urandom, $urandom};
      offer(it, 1'b0, '0, 1'b0);
    end
  endtask

  task automatic take_result();
    win_result_t want;
    logic [63:0] got_value;
    logic [63:0] got_time;
    got_value = m_axis_tdata[63:0];
    got_time  = m_axis_tdata[127:64];
    results_seen++;
    if (window_q.size() == 0) begin
      $display("%0t: unexpected result value %h time %h empty %b", $time, got_value,
               got_time, m_axis_tuser[0]);
      errors++;
      return;
    end
    want = window_q.pop_front();
    if (got_value !== want.value) begin
      $display("%0t: result_value expected %h actual %h", $time, want.value, got_value);
      errors++;
    end
    if (got_time !== want.tstamp) begin
      $display("%0t: result_time expected %h actual %h", $time, want.tstamp, got_time);
      errors++;
    end
    if (m_axis_tuser[0] !== want.empty) begin
      $display("%0t: empty_window expected %b actual %b", $time, want.empty,
               m_axis_tuser[0]);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, window_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned idle_left;
    bit          hold_done;
    hold_left = 0;
    idle_left = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) take_result();
      if (hold_req && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    win_item_t         it;
    logic [MODE_W-1:0] phase_modes [N_PHASES];
    int                i;
    int                ph;
    int unsigned       start;
    clear_window();
    phase_modes = '{MODE_AVG, MODE_SUM, MODE_COUNT, MODE_MIN, MODE_MAX, MODE_RSVD_HI,
                    MODE_COUNT, MODE_AVG};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < N_PLAN; i++) begin
      if (plan[i].mode != mode_q) set_mode(plan[i].mode);
      it.has    = plan[i].has;
      it.ok     = plan[i].ok;
      it.value  = plan[i].value;
      it.last   = plan[i].last;
      it.tstamp = plan[i].tstamp;
      offer(it, plan[i].known, plan[i].exp_value, plan[i].exp_empty);
    end

    calm = 1'b1;
    long_window(MODE_SUM, VAL_MAX, 1'b0);
    long_window(MODE_AVG, VAL_MIN, 1'b0);
    long_window(MODE_COUNT, '0, 1'b1);
    calm = 1'b0;

    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 6) set_mode(MODE_W'($urandom_range(0, 7)));
      else set_mode(phase_modes[ph]);
      if (ph == N_PHASES - 1) calm = 1'b1;
      start = items_sent;
      if (ph == 2) begin
        hold_req = 1'b1;
        while (items_sent - start < PHASE_ITEMS) send_window(1);
      end else begin
        while (items_sent - start < PHASE_ITEMS)
          send_window(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items closing %0d windows; checked %0d results.", items_sent,
             windows_closed, results_seen);
    $display("Covered all aggregate kinds, reserved modes, empty windows, long windows, stalls.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
